>>> rtl/stkspan_pkg.sv
// Shared constants and types for the stock span core.
// No dependencies; compile first.
`default_nettype none

package stkspan_pkg;

   localparam int unsigned MAX_DAYS = 1024;
   localparam int unsigned PRICE_W  = 32;
   localparam int unsigned SPAN_W   = 11;
   // day and level counters must hold MAX_DAYS itself
   localparam int unsigned LVL_W    = $clog2(MAX_DAYS + 1);
   localparam int unsigned ADDR_W   = $clog2(MAX_DAYS);
   localparam int unsigned ENTRY_W  = PRICE_W + ADDR_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_PUSH
   } state_type;

endpackage

`default_nettype wire

>>> rtl/stkspan_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on stkspan_pkg.
`default_nettype none

interface stkspan_req_if import stkspan_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PRICE_W-1:0] price;
   logic                      first;

   modport source (output valid, output price, output first, input ready);
   modport sink   (input valid, input price, input first, output ready);
endinterface

interface stkspan_rsp_if import stkspan_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SPAN_W-1:0] span;
   logic              overflow;

   modport source (output valid, output span, output overflow, input ready);
   modport sink   (input valid, input span, input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/stkspan_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module stkspan_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/stock_span_monotonic_stack_core.sv
// Requests are taken only in the idle state, so a new price waits until the last is done.
// Each price is compared against the stack top, popping entries (one stack RAM read per cycle)
// until a greater price or an empty stack; a held response stalls the push of the price.
// Reset (synchronous, active high) empties the stack, zeroes the day count and drops
// the response; stack RAM contents are not cleared.
// Depends on stkspan_pkg, stkspan_if, stkspan_ram.
`default_nettype none

module stock_span_monotonic_stack_core import stkspan_pkg::*; (
   input wire logic      clock,
   input wire logic      reset,
   stkspan_req_if.sink   req_chan,
   stkspan_rsp_if.source rsp_chan
);

   state_type                 state_ff, state_in;
   logic [LVL_W-1:0]          level_ff, level_in;
   logic [LVL_W-1:0]          day_ff, day_in;
   logic signed [PRICE_W-1:0] price_ff, price_in;
   logic [SPAN_W-1:0]         span_ff, span_in;
   logic                      ovf_ff, ovf_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SPAN_W-1:0]         rsp_span_ff, rsp_span_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                      ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]         ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]        ram_wr_data, ram_rd_data;

   logic signed [PRICE_W-1:0] top_price;
   logic [ADDR_W-1:0]         top_day;
   logic                      slot_free;
   logic                      fin;
   logic [SPAN_W-1:0]         fin_span;
   logic                      fin_ovf;
   logic [LVL_W-1:0]          acc_level, acc_day, pop_level, cand_span;

   stkspan_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_DAYS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign top_price = ram_rd_data[ENTRY_W-1 -: PRICE_W];
   assign top_day   = ram_rd_data[ADDR_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign acc_level = req_chan.first ? '0 : level_ff;
   assign acc_day   = req_chan.first ? '0 : day_ff;
   assign pop_level = level_ff - LVL_W'(1);
   assign cand_span = day_ff - {{(LVL_W-ADDR_W){1'b0}}, top_day};

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      day_in       = day_ff;
      price_in     = price_ff;
      span_in      = span_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_span_in  = rsp_span_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pop_level[ADDR_W-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = level_ff[ADDR_W-1:0];
      ram_wr_data  = {price_ff, day_ff[ADDR_W-1:0]};
      req_chan.ready = 1'b0;
      fin          = 1'b0;
      fin_span     = span_ff;
      fin_ovf      = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               price_in = req_chan.price;
               level_in = acc_level;
               day_in   = acc_day;
               ovf_in   = 1'b0;
               if (acc_day == LVL_W'(MAX_DAYS)) begin
                  ovf_in   = 1'b1;
                  span_in  = '0;
                  state_in = ST_PUSH;
               end else if (acc_level != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_W'(acc_level - LVL_W'(1));
                  state_in    = ST_CMP;
               end else begin
                  span_in  = SPAN_W'(acc_day + LVL_W'(1));
                  state_in = ST_PUSH;
               end
            end
         end
         ST_CMP: begin
            if (top_price <= price_ff) begin
               // top is not greater: pop it and look at the next one down
               level_in = pop_level;
               if (pop_level != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ADDR_W'(pop_level - LVL_W'(1));
               end else begin
                  span_in  = SPAN_W'(day_ff + LVL_W'(1));
                  state_in = ST_PUSH;
               end
            end else if (slot_free) begin
               fin      = 1'b1;
               fin_span = SPAN_W'(cand_span);
               fin_ovf  = 1'b0;
            end else begin
               span_in  = SPAN_W'(cand_span);
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (slot_free) begin
               fin = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         if (!fin_ovf) begin
            ram_wr_en = 1'b1;
            level_in  = level_ff + LVL_W'(1);
            day_in    = day_ff + LVL_W'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_span_in  = fin_span;
         rsp_ovf_in   = fin_ovf;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         day_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         day_ff       <= day_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff    <= price_in;
      span_ff     <= span_in;
      ovf_ff      <= ovf_in;
      rsp_span_ff <= rsp_span_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.span     = rsp_span_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> rtl/stkspan_chk.sv
// Port-level checks for the stock span core, bound to the top level.
// Depends on stkspan_pkg.
`default_nettype none

module stkspan_chk import stkspan_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [SPAN_W-1:0] rsp_span,
   input wire logic              rsp_overflow
);

   // a held response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span) && $stable(rsp_overflow))
      else $error("response dropped or changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_span == '0)
      else $error("overflow item with nonzero span");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow |-> rsp_span != '0 && rsp_span <= SPAN_W'(MAX_DAYS))
      else $error("span out of range");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind stock_span_monotonic_stack_core stkspan_chk u_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_span     (rsp_chan.span),
   .rsp_overflow (rsp_chan.overflow)
);

`default_nettype wire

>>> tb/stock_span_monotonic_stack_core_check.sv
// Checker for the stock span core: watches the request and response channels,
// predicts each span with a private monotonic stack and compares field by field.
// Depends on stkspan_pkg and stkspan_if.
module stock_span_monotonic_stack_core_check import stkspan_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   stkspan_req_if      req_mon,
   stkspan_rsp_if      rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned spans_checked,
   output int unsigned overflows_seen,
   output int unsigned longest_span
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SPAN_W-1:0] span;
      logic              overflow;
   } span_result_type;

   span_result_type span_due[$];

   // predictor state: prices strictly falling from bottom to top
   logic signed [PRICE_W-1:0] peak_price [MAX_DAYS];
   logic [ADDR_W-1:0]         peak_day   [MAX_DAYS];
   logic [LVL_W-1:0]          peak_level;
   logic [LVL_W-1:0]          day_num;

   function automatic span_result_type predict_span(input logic signed [PRICE_W-1:0] price,
                                                    input logic first);
      span_result_type res;
      if (first) begin
         peak_level = '0;
         day_num    = '0;
      end
      // series too long: report and leave the stack alone
      if (day_num >= MAX_DAYS) begin
         res.span     = '0;
         res.overflow = 1'b1;
         return res;
      end
      while (peak_level > 0 && peak_price[peak_level - 1] <= price)
         peak_level = peak_level - 1'b1;
      res.overflow = 1'b0;
      if (peak_level > 0)
         res.span = SPAN_W'(day_num - peak_day[peak_level - 1]);
      else
         res.span = SPAN_W'(day_num + 1'b1);
      if (peak_level < MAX_DAYS) begin
         peak_price[peak_level] = price;
         peak_day[peak_level]   = ADDR_W'(day_num);
         peak_level             = peak_level + 1'b1;
      end
      day_num = day_num + 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      span_result_type want;
      span_result_type due;
      if (reset) begin
         span_due.delete();
         peak_level     = '0;
         day_num        = '0;
         fail_count     = 0;
         spans_checked  = 0;
         overflows_seen = 0;
         longest_span   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (span_due.size() == 0) begin
               $error("unexpected result item: span %0d overflow %0b",
                      rsp_mon.span, rsp_mon.overflow);
               fail_count++;
            end else begin
               want = span_due.pop_front();
               spans_checked++;
               if (want.overflow)
                  overflows_seen++;
               if (want.span > longest_span)
                  longest_span = want.span;
               if (rsp_mon.span !== want.span) begin
                  $error("span mismatch: expected %0d, actual %0d", want.span, rsp_mon.span);
                  fail_count++;
               end
               if (rsp_mon.overflow !== want.overflow) begin
                  $error("overflow mismatch: expected %0b, actual %0b",
                         want.overflow, rsp_mon.overflow);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            due      = predict_span(req_mon.price, req_mon.first);
            span_due = {span_due, due};
         end
      end
      pending = span_due.size();
   end

endmodule

>>> tb/stock_span_monotonic_stack_core_test.sv
// Top of the stock span testbench: clock, reset, price stimulus and response-side stalls.
// Checking is done by stock_span_monotonic_stack_core_check.
// Depends on stkspan_pkg, stkspan_if, the core and the checker.
module stock_span_monotonic_stack_core_test;
   import stkspan_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [PRICE_W-1:0] PRICE_MIN = {1'b1, {(PRICE_W-1){1'b0}}};
   localparam logic signed [PRICE_W-1:0] PRICE_MAX = {1'b0, {(PRICE_W-1){1'b1}}};
   localparam int RANDOM_ITEMS    = 220;
   localparam int DEEP_ITEMS      = 300;
   localparam int PRESSURE_SERIES = 3;
   localparam int HOLD_CYCLES     = 120;
   localparam int TAIL_CYCLES     = 40;
   // the limit must cover a pop through a full stack of MAX_DAYS entries
   localparam int QUIET_LIMIT     = 10000;

   typedef enum int {
      PM_TIES,
      PM_FULL,
      PM_WALK,
      PM_EXTREME,
      PM_FALLING
   } price_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on  = 1'b0;
   logic hold_rsp = 1'b0;
   int unsigned items_sent   = 0;
   int unsigned series_count = 0;
   int unsigned quiet_cycles = 0;

   int unsigned fail_count, pending, spans_checked, overflows_seen, longest_span;

   stkspan_req_if req_chan ();
   stkspan_rsp_if rsp_chan ();

   stock_span_monotonic_stack_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   stock_span_monotonic_stack_core_check span_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .fail_count     (fail_count),
      .pending        (pending),
      .spans_checked  (spans_checked),
      .overflows_seen (overflows_seen),
      .longest_span   (longest_span)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [PRICE_W-1:0] next_price(input price_mode_type mode,
                                                           input logic signed [PRICE_W-1:0] prev);
      logic signed [PRICE_W-1:0] p;
      case (mode)
         PM_TIES:  p = int'($urandom_range(0, 6)) - 3;
         PM_FULL:  p = $urandom;
         PM_WALK:  p = prev + int'($urandom_range(0, 20)) - 10;
         PM_EXTREME: begin
            case ($urandom_range(0, 5))
               0:       p = PRICE_MIN;
               1:       p = PRICE_MAX;
               2:       p = 0;
               3:       p = -1;
               4:       p = PRICE_MIN + 1;
               default: p = PRICE_MAX - 1;
            endcase
         end
         default: begin
            // falling run with an occasional spike that pops a stretch
            if ($urandom_range(0, 15) == 0)
               p = prev + int'($urandom_range(0, 400));
            else
               p = prev - int'($urandom_range(1, 5));
         end
      endcase
      return p;
   endfunction

   task automatic send_item(input logic signed [PRICE_W-1:0] price, input logic first);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.price = price;
      req_chan.first = first;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap_len()) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results pending",
                  QUIET_LIMIT, pending);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic signed [PRICE_W-1:0] p;
      price_mode_type mode;
      int series_len;
      int r;
      int random_items;

      req_chan.valid = 1'b0;
      req_chan.price = '0;
      req_chan.first = 1'b0;
      random_items   = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // rising run with a tie at the top, then a falling run and a partial pop
      send_item(PRICE_MIN, 1'b1);
      send_item(-1, 1'b0);
      send_item(0, 1'b0);
      send_item(1, 1'b0);
      send_item(PRICE_MAX, 1'b0);
      send_item(PRICE_MAX, 1'b0);
      send_item(100, 1'b0);
      send_item(50, 1'b0);
      send_item(-50, 1'b0);
      send_item(PRICE_MIN, 1'b0);
      send_item(60, 1'b0);
      send_item(-50, 1'b0);
      send_item(60, 1'b0);
      // restart with a loaded stack, equal prices, alternating bit patterns
      send_item(0, 1'b1);
      send_item(0, 1'b0);
      send_item(0, 1'b0);
      send_item(32'sh5555_5555, 1'b0);
      send_item(32'shAAAA_AAAA, 1'b0);
      series_count = 2;

      // one deep series: long falling stack, then a price that pops it all,
      // then a restart
      idle_on = 1'b1;
      p = 2_000_000;
      send_item(p, 1'b1);
      for (int k = 1; k < DEEP_ITEMS; k++) begin
         p = p - 1 - int'($urandom_range(0, 3));
         send_item(p, 1'b0);
      end
      send_item(PRICE_MAX, 1'b0);
      send_item($urandom, 1'b1);
      series_count++;

      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         series_len = (r < 7) ? $urandom_range(2, 40) :
                      (r < 9) ? $urandom_range(1, 5) : $urandom_range(60, 200);
         mode    = price_mode_type'($urandom_range(0, 4));
         idle_on = ($urandom_range(0, 3) != 0);
         if (series_count == PRESSURE_SERIES + 1) begin
            // sender keeps pushing while the response side holds off
            idle_on    = 1'b0;
            series_len = 40;
            hold_rsp   = 1'b1;
         end
         p = $urandom;
         for (int k = 0; k < series_len; k++) begin
            p = next_price(mode, p);
            // stray restarts inside a series now and then
            send_item(p, k == 0 || $urandom_range(0, 49) == 0);
            random_items++;
         end
         series_count++;
      end

      req_chan.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d price items in %0d series; %0d spans checked, %0d past the day limit,",
               items_sent, series_count, spans_checked, overflows_seen);
      $display("longest span seen %0d, with random stalls on both channels.", longest_span);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/stkspan_pkg.sv
rtl/stkspan_if.sv
rtl/stkspan_ram.sv
rtl/stock_span_monotonic_stack_core.sv
rtl/stkspan_chk.sv
tb/stock_span_monotonic_stack_core_check.sv
tb/stock_span_monotonic_stack_core_test.sv
